>>> rtl/wmvm_pkg.sv
// ----------------------------------------------------------------------------
// wmvm_pkg: shared types and constants for the word memory executor
// Opcodes, status codes, redirect codes and the queue entry type.
// ----------------------------------------------------------------------------
package wmvm_pkg;

  localparam int unsigned MemWords = 1024;
  localparam int unsigned AddrW    = $clog2(MemWords);
  localparam int unsigned CfgW     = 11;

  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_SET   = 8'd149;
  localparam logic [7:0] OP_LOAD  = 8'd93;
  localparam logic [7:0] OP_STORE = 8'd99;
  localparam logic [7:0] OP_JUMP  = 8'd145;
  localparam logic [7:0] OP_SGZ   = 8'd37;
  localparam logic [7:0] OP_ADD   = 8'd173;
  localparam logic [7:0] OP_MUL   = 8'd51;
  localparam logic [7:0] OP_DIV   = 8'd4;
  localparam logic [7:0] OP_MOD   = 8'd181;
  localparam logic [7:0] OP_OUT   = 8'd193;
  localparam logic [7:0] OP_SLEEP = 8'd191;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADOP  = 3'd1;
  localparam logic [2:0] ST_BADADR = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_NEGJMP = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_JUMP = 2'd1;
  localparam logic [1:0] RD_SKIP = 2'd2;

  localparam logic [63:0] SleepDiv = 64'd1000;

  // ceil(2^67 / 125): for n up to 2^60, (n * SleepRecip) >> 67 is n / 125,
  // so a magnitude shifted right by 3 gives the magnitude / 1000
  localparam logic [63:0] SleepRecip = 64'd1180591620717411304;

  // decoded request passed from front to back
  typedef struct packed {
    logic [7:0]  op;
    logic        bad_op;
    logic        bad_a;
    logic        bad_b;
    logic        bad_c;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } req_t;

endpackage

>>> rtl/wmvm_front.sv
// ----------------------------------------------------------------------------
// wmvm_front: request intake and classification
// Checks the opcode and direct addresses and pushes the request into a
// two-entry queue toward the execution side.
// ----------------------------------------------------------------------------
module wmvm_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_req_type,
  input  logic signed [63:0]      in_operand_a,
  input  logic signed [63:0]      in_operand_b,
  input  logic signed [63:0]      in_operand_c,
  input  logic [wmvm_pkg::CfgW-1:0] lim,
  output logic                    q_valid,
  input  logic                    q_ready,
  output wmvm_pkg::req_t          q_req
);
  import wmvm_pkg::*;

  req_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       dec;
  logic       push, pop;

  function automatic logic bad_addr(input logic [63:0] v, input logic [CfgW-1:0] l);
    bad_addr = (v[63:CfgW] != '0) || (v[CfgW-1:0] >= l);
  endfunction

  // classify the incoming request
  always_comb begin
    dec.op    = in_req_type;
    dec.a     = in_operand_a;
    dec.b     = in_operand_b;
    dec.c     = in_operand_c;
    dec.bad_a = bad_addr(in_operand_a, lim);
    dec.bad_b = bad_addr(in_operand_b, lim);
    dec.bad_c = bad_addr(in_operand_c, lim);
    unique case (in_req_type)
      OP_NOP, OP_SET, OP_LOAD, OP_STORE, OP_JUMP, OP_SGZ, OP_ADD,
      OP_MUL, OP_DIV, OP_MOD, OP_OUT, OP_SLEEP: dec.bad_op = 1'b0;
      default:                                   dec.bad_op = 1'b1;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = ent_r[rp_r];

  // hold queue entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= dec;
    end
  end

  // advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r == 2'd2 |-> !push)
    else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
      push && !pop && cnt_r != 2'd2 |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count not advanced");

endmodule

>>> rtl/wmvm_divider.sv
// ----------------------------------------------------------------------------
// wmvm_divider: signed 64-bit divider
// Restoring divider, one quotient bit per cycle; truncates toward zero.
// ----------------------------------------------------------------------------
module wmvm_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  import wmvm_pkg::*;

  logic [63:0] q_r, d_r;
  logic [64:0] r_r;
  logic [6:0]  cnt_r;
  logic        busy_r, nq_r, nr_r, done_r;
  logic [64:0] trial;
  logic [64:0] shl;

  assign shl   = {r_r[63:0], q_r[63]};
  assign trial = shl - {1'b0, d_r};

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        nq_r   <= dividend[63] ^ divisor[63];
        nr_r   <= dividend[63];
        q_r    <= dividend[63] ? (64'd0 - dividend) : dividend;
        d_r    <= divisor[63] ? (64'd0 - divisor) : divisor;
        r_r    <= '0;
      end else if (busy_r) begin
        if (!trial[64]) begin
          r_r <= trial;
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          r_r <= shl;
          q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = nq_r ? (64'd0 - q_r) : q_r;
  assign rem  = nr_r ? (64'd0 - r_r[63:0]) : r_r[63:0];

endmodule

>>> rtl/wmvm_back.sv
// ----------------------------------------------------------------------------
// wmvm_back: instruction execution
// Sequencer that reads memory, runs arithmetic, writes back and
// presents one result per request in an output register.
// ----------------------------------------------------------------------------
module wmvm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [wmvm_pkg::CfgW-1:0] lim,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  wmvm_pkg::req_t            q_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [1:0]                out_redirect,
  output logic [62:0]               out_jump_target,
  output logic                      out_char_valid,
  output logic [7:0]                out_out_char,
  output logic [31:0]               out_sleep_seconds
);
  import wmvm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_WT1, S_RD2, S_WT2, S_MUL,
    S_DIV, S_DWAIT, S_SL1, S_SL2, S_SL3, S_WB, S_DONE
  } state_t;

  state_t          state_r;
  req_t            req_r;
  logic [63:0]     mem [MemWords];
  logic [AddrW-1:0] raddr_r, waddr_r, clr_r;
  logic [63:0]     rdata_r, wdata_r, x_r, y_r;
  logic            we_r, halted_r, dstart_r;
  logic [63:0]     mlo_r, mhi_r;
  logic [2:0]      st_r;
  logic [1:0]      rd_r;
  logic [62:0]     tgt_r;
  logic            cv_r;
  logic [7:0]      ch_r;
  logic [31:0]     sl_r;
  logic            sneg_r;
  logic [65:0]     sum_r;
  logic [66:0]     sl_sum;
  logic            dv_done;
  logic [63:0]     dv_q, dv_r;
  logic [63:0]     dv_a, dv_b;

  function automatic logic bad_addr(input logic [63:0] v, input logic [CfgW-1:0] l);
    bad_addr = (v[63:CfgW] != '0) || (v[CfgW-1:0] >= l);
  endfunction

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we_r) mem[waddr_r] <= wdata_r;
    rdata_r <= mem[raddr_r];
  end

  assign dv_a = x_r;
  assign dv_b = y_r;

  // product shifted right by 32, enough bits for the low quotient word
  assign sl_sum = 67'(sum_r) + {y_r[34:0], 32'd0};

  wmvm_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(dv_a),
    .divisor(dv_b), .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_status        = st_r;
  assign out_redirect      = rd_r;
  assign out_jump_target   = tgt_r;
  assign out_char_valid    = cv_r;
  assign out_out_char      = ch_r;
  assign out_sleep_seconds = sl_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      we_r     <= 1'b0;
      halted_r <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      we_r     <= 1'b0;
      dstart_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          we_r    <= 1'b1;
          waddr_r <= clr_r;
          wdata_r <= '0;
          clr_r   <= clr_r + 1'b1;
          if (clr_r == AddrW'(MemWords - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            st_r  <= ST_OK;
            rd_r  <= RD_NONE;
            tgt_r <= '0;
            cv_r  <= 1'b0;
            ch_r  <= '0;
            sl_r  <= '0;
            if (halted_r) begin
              st_r    <= ST_HALTED;
              state_r <= S_DONE;
            end else if (q_req.bad_op) begin
              st_r    <= ST_BADOP;
              state_r <= S_WB;
            end else begin
              unique case (q_req.op)
                OP_NOP: state_r <= S_DONE;
                OP_SET: begin
                  if (q_req.bad_a) st_r <= ST_BADADR;
                  else begin
                    we_r    <= 1'b1;
                    waddr_r <= q_req.a[AddrW-1:0];
                    wdata_r <= q_req.b;
                  end
                  state_r <= S_WB;
                end
                OP_LOAD: begin
                  raddr_r <= q_req.b[AddrW-1:0];
                  if (q_req.bad_b) begin
                    st_r <= ST_BADADR; state_r <= S_WB;
                  end else state_r <= S_RD1;
                end
                OP_ADD, OP_MUL, OP_DIV, OP_MOD: begin
                  raddr_r <= q_req.b[AddrW-1:0];
                  if (q_req.bad_a || q_req.bad_b || q_req.bad_c) begin
                    st_r <= ST_BADADR; state_r <= S_WB;
                  end else state_r <= S_RD1;
                end
                default: begin
                  raddr_r <= q_req.a[AddrW-1:0];
                  if (q_req.bad_a) begin
                    st_r <= ST_BADADR; state_r <= S_WB;
                  end else state_r <= S_RD1;
                end
              endcase
            end
          end
        end
        S_RD1: state_r <= S_WT1;
        S_WT1: begin
          x_r <= rdata_r;
          unique case (req_r.op)
            OP_LOAD: begin
              raddr_r <= rdata_r[AddrW-1:0];
              if (bad_addr(rdata_r, lim) || req_r.bad_a) begin
                st_r <= ST_BADADR; state_r <= S_WB;
              end else state_r <= S_RD2;
            end
            OP_STORE: begin
              raddr_r <= req_r.b[AddrW-1:0];
              if (bad_addr(rdata_r, lim) || req_r.bad_b) begin
                st_r <= ST_BADADR; state_r <= S_WB;
              end else state_r <= S_RD2;
            end
            OP_ADD, OP_MUL, OP_DIV, OP_MOD: begin
              raddr_r <= req_r.c[AddrW-1:0];
              state_r <= S_RD2;
            end
            OP_JUMP: begin
              if (rdata_r[63]) st_r <= ST_NEGJMP;
              else begin
                rd_r  <= RD_JUMP;
                tgt_r <= rdata_r[62:0];
              end
              state_r <= S_WB;
            end
            OP_SGZ: begin
              if (rdata_r != '0 && !rdata_r[63]) rd_r <= RD_SKIP;
              state_r <= S_WB;
            end
            OP_OUT: begin
              cv_r    <= 1'b1;
              ch_r    <= rdata_r[7:0];
              state_r <= S_WB;
            end
            OP_SLEEP: begin
              // take the magnitude over 8, then divide by 125 by reciprocal
              sneg_r  <= rdata_r[63];
              y_r     <= (rdata_r[63] ? (64'd0 - rdata_r) : rdata_r) >> 3;
              state_r <= S_SL1;
            end
            default: state_r <= S_WB;
          endcase
        end
        S_RD2: state_r <= S_WT2;
        S_WT2: begin
          y_r <= rdata_r;
          unique case (req_r.op)
            OP_LOAD: begin
              we_r <= 1'b1; waddr_r <= req_r.a[AddrW-1:0]; wdata_r <= rdata_r;
              state_r <= S_WB;
            end
            OP_STORE: begin
              we_r <= 1'b1; waddr_r <= x_r[AddrW-1:0]; wdata_r <= rdata_r;
              state_r <= S_WB;
            end
            OP_ADD: begin
              we_r <= 1'b1; waddr_r <= req_r.a[AddrW-1:0];
              wdata_r <= x_r + rdata_r;
              state_r <= S_WB;
            end
            OP_MUL: state_r <= S_MUL;
            default: begin
              if (rdata_r == '0) begin
                st_r <= ST_DIVZ; state_r <= S_WB;
              end else begin
                dstart_r <= 1'b1; state_r <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          // 32x32 partial products, summed next cycle
          mlo_r   <= x_r[31:0] * y_r[31:0];
          mhi_r   <= {32'd0, x_r[63:32] * y_r[31:0]};
          x_r     <= {32'd0, x_r[31:0] * y_r[63:32]};
          state_r <= S_DWAIT;
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (req_r.op == OP_MUL) begin
            we_r    <= 1'b1;
            waddr_r <= req_r.a[AddrW-1:0];
            wdata_r <= mlo_r + {mhi_r[31:0] + x_r[31:0], 32'd0};
            state_r <= S_WB;
          end else if (dv_done) begin
            we_r    <= 1'b1;
            waddr_r <= req_r.a[AddrW-1:0];
            wdata_r <= (req_r.op == OP_DIV) ? dv_q : dv_r;
            state_r <= S_WB;
          end
        end
        S_SL1: begin
          // four 32x32 partial products of the scaled magnitude and reciprocal
          mlo_r   <= y_r[31:0] * SleepRecip[31:0];
          mhi_r   <= y_r[31:0] * SleepRecip[63:32];
          x_r     <= y_r[63:32] * SleepRecip[31:0];
          y_r     <= y_r[63:32] * SleepRecip[63:32];
          state_r <= S_SL2;
        end
        S_SL2: begin
          // add the middle terms and the carry out of the low term
          sum_r   <= 66'(mlo_r[63:32]) + 66'(mhi_r) + 66'(x_r);
          state_r <= S_SL3;
        end
        S_SL3: begin
          // take bits 67 and up of the product, then restore the sign
          sl_r    <= sneg_r ? (32'd0 - sl_sum[66:35]) : sl_sum[66:35];
          state_r <= S_WB;
        end
        S_WB: begin
          if (st_r != ST_OK) begin
            halted_r <= 1'b1;
            rd_r <= RD_NONE; tgt_r <= '0; cv_r <= 1'b0; ch_r <= '0; sl_r <= '0;
          end
          state_r <= S_DONE;
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_WB && st_r != ST_OK |=> halted_r)
    else $error("error did not halt");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
      halted_r |=> halted_r)
    else $error("halt dropped");
  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
      $past(halted_r) && state_r != S_CLEAR |-> !we_r)
    else $error("memory written while halted");

endmodule

>>> rtl/word_memory_vm_execute.sv
// ----------------------------------------------------------------------------
// word_memory_vm_execute: word memory instruction executor
// Runs one instruction per request on a 1024-word, 64-bit memory.
// ----------------------------------------------------------------------------
// After reset the memory is cleared one word a cycle; the two-entry queue
// may take up to two requests meanwhile, but none executes until the clear
// is done. A sequencer that owns the memory's one write and one read port
// runs one request at a time. Sleep divides by 1000 with a shift by 3 and a
// reciprocal multiply by 1/125; divide and modulo use the 64-step divider.
// An error goes through the write-back state to its result, and a halted
// block answers straight from idle. One result comes back per request,
// in order.
module word_memory_vm_execute (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_req_type,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  input  logic signed [63:0] in_operand_c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [1:0]         out_redirect,
  output logic [62:0]        out_jump_target,
  output logic               out_char_valid,
  output logic [7:0]         out_out_char,
  output logic [31:0]        out_sleep_seconds,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_ram_words
);
  import wmvm_pkg::*;

  logic [CfgW-1:0] ram_words_r, lim;
  logic            q_valid, q_ready;
  req_t            q_req;

  // hold the size register
  always_ff @(posedge clk) begin
    if (!rst_n) ram_words_r <= CfgW'(MemWords);
    else if (cfg_we) ram_words_r <= cfg_ram_words;
  end

  assign lim = (ram_words_r > CfgW'(MemWords)) ? CfgW'(MemWords) : ram_words_r;

  wmvm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .in_operand_c(in_operand_c), .lim(lim),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  wmvm_back u_back (
    .clk(clk), .rst_n(rst_n), .lim(lim), .q_valid(q_valid), .q_ready(q_ready),
    .q_req(q_req), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_redirect(out_redirect),
    .out_jump_target(out_jump_target), .out_char_valid(out_char_valid),
    .out_out_char(out_out_char), .out_sleep_seconds(out_sleep_seconds)
  );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for word_memory_vm_execute
// Drives instruction requests with random gaps, predicts every result from
// its own copy of the word memory, halt flag and memory size, and compares
// the results field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import wmvm_pkg::*;

  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  redirect;
    logic [62:0] jump_target;
    logic        char_valid;
    logic [7:0]  out_char;
    logic [31:0] sleep_seconds;
  } exec_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_req_type = '0;
  logic signed [63:0] in_operand_a = '0;
  logic signed [63:0] in_operand_b = '0;
  logic signed [63:0] in_operand_c = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [1:0]         out_redirect;
  logic [62:0]        out_jump_target;
  logic               out_char_valid;
  logic [7:0]         out_out_char;
  logic [31:0]        out_sleep_seconds;
  logic               cfg_we = 1'b0;
  logic [10:0]        cfg_ram_words = '0;

  // predictor state
  logic [63:0]  model_mem [MemWords];
  logic         model_halted;
  logic [10:0]  model_words;
  exec_result_t pending_results [$];

  int  mismatch_count = 0;
  int  result_count = 0;
  int  request_count = 0;
  int  idle_cycles = 0;
  bit  ready_random = 1'b1;

  word_memory_vm_execute DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .in_operand_c(in_operand_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_redirect(out_redirect),
    .out_jump_target(out_jump_target), .out_char_valid(out_char_valid),
    .out_out_char(out_out_char), .out_sleep_seconds(out_sleep_seconds),
    .cfg_we(cfg_we), .cfg_ram_words(cfg_ram_words)
  );

  always #5 clk = ~clk;

  function automatic bit addr_valid(logic [63:0] v);
    logic [63:0] lim;
    lim = (model_words < MemWords) ? 64'(model_words) : 64'(MemWords);
    return v < lim;
  endfunction

  function automatic logic [63:0] mem_rd(logic [63:0] v);
    return model_mem[v[AddrW-1:0]];
  endfunction

  // signed divide truncating toward zero, returns quotient or remainder
  function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d, bit want_rem);
    logic [63:0] mn, md, mq, mr;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    mq = mn / md;
    mr = mn % md;
    if (want_rem) return n[63] ? -mr : mr;
    return (n[63] != d[63]) ? -mq : mq;
  endfunction

  // execute one instruction on the predictor and return its result
  function automatic exec_result_t execute_instr(logic [7:0] op, logic [63:0] a,
                                                 logic [63:0] b, logic [63:0] c);
    exec_result_t res;
    logic [2:0]   st;
    logic [63:0]  t, q;
    res = '0;
    st = ST_OK;
    if (model_halted) begin
      res.status = ST_HALTED;
      return res;
    end
    case (op)
      OP_NOP: ;
      OP_SET: begin
        if (!addr_valid(a)) st = ST_BADADR;
        else model_mem[a[AddrW-1:0]] = b;
      end
      OP_LOAD: begin
        if (!addr_valid(b)) st = ST_BADADR;
        else begin
          t = mem_rd(b);
          if (!addr_valid(t) || !addr_valid(a)) st = ST_BADADR;
          else model_mem[a[AddrW-1:0]] = mem_rd(t);
        end
      end
      OP_STORE: begin
        if (!addr_valid(a)) st = ST_BADADR;
        else begin
          t = mem_rd(a);
          if (!addr_valid(t) || !addr_valid(b)) st = ST_BADADR;
          else model_mem[t[AddrW-1:0]] = mem_rd(b);
        end
      end
      OP_JUMP: begin
        if (!addr_valid(a)) st = ST_BADADR;
        else begin
          t = mem_rd(a);
          if (t[63]) st = ST_NEGJMP;
          else begin
            res.redirect = RD_JUMP;
            res.jump_target = t[62:0];
          end
        end
      end
      OP_SGZ: begin
        if (!addr_valid(a)) st = ST_BADADR;
        else begin
          t = mem_rd(a);
          if (t != 0 && !t[63]) res.redirect = RD_SKIP;
        end
      end
      OP_ADD, OP_MUL, OP_DIV, OP_MOD: begin
        if (!addr_valid(a) || !addr_valid(b) || !addr_valid(c)) st = ST_BADADR;
        else if (op == OP_ADD) model_mem[a[AddrW-1:0]] = mem_rd(b) + mem_rd(c);
        else if (op == OP_MUL) model_mem[a[AddrW-1:0]] = mem_rd(b) * mem_rd(c);
        else if (mem_rd(c) == 0) st = ST_DIVZ;
        else model_mem[a[AddrW-1:0]] = sdiv(mem_rd(b), mem_rd(c), op == OP_MOD);
      end
      OP_OUT: begin
        if (!addr_valid(a)) st = ST_BADADR;
        else begin
          t = mem_rd(a);
          res.char_valid = 1'b1;
          res.out_char = t[7:0];
        end
      end
      OP_SLEEP: begin
        if (!addr_valid(a)) st = ST_BADADR;
        else begin
          q = sdiv(mem_rd(a), SleepDiv, 1'b0);
          res.sleep_seconds = q[31:0];
        end
      end
      default: st = ST_BADOP;
    endcase
    if (st != ST_OK) begin
      model_halted = 1'b1;
      res = '0;
      res.status = st;
    end
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, field, got,
             want);
  endtask

  // send one request and predict its result at acceptance; valid stays high
  // when the next request follows with no gap
  task automatic send_instr(logic [7:0] op, logic [63:0] a, logic [63:0] b,
                            logic [63:0] c, bit use_gap = 1'b1);
    int gap;
    gap = use_gap ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_c <= c;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(execute_instr(op, a, b, c));
    request_count++;
    @(negedge clk);
  endtask

  // wait for all results, then write the memory size register
  task automatic set_ram_words(logic [10:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_ram_words <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_words = value;
  endtask

  // clear halt: the only way back is reset, so the halted state is tested last
  // in the run; before that the predictor must stay unhalted.
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_addr();
    int unsigned lim;
    lim = (model_words < MemWords) ? model_words : MemWords;
    if (lim == 0 || $urandom_range(0, 49) == 0) begin
      case ($urandom_range(0, 3))
        0: return rand64();
        1: return 64'(lim);
        2: return -64'sd1;
        default: return 64'(MemWords + $urandom_range(0, 1200));
      endcase
    end
    return 64'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return 64'($urandom_range(0, 40));
      2: return -64'($urandom_range(0, 5));
      3: return {1'b1, 63'($urandom_range(0, 3))};
      4: return 64'(MemWords - 1) - $urandom_range(0, 3);
      default: return 64'($urandom_range(0, 2000000));
    endcase
  endfunction

  function automatic logic [7:0] rand_op(bit allow_bad);
    logic [7:0] ops [12];
    logic [7:0] op;
    ops = '{OP_NOP, OP_SET, OP_LOAD, OP_STORE, OP_JUMP, OP_SGZ, OP_ADD, OP_MUL,
            OP_DIV, OP_MOD, OP_OUT, OP_SLEEP};
    if (allow_bad) begin
      op = 8'($urandom());
      return op;
    end
    op = ops[$urandom_range(0, 11)];
    return op;
  endfunction

  // directed: every operation with extreme values, without errors
  task automatic test_directed();
    send_instr(OP_NOP, '1, '1, '1);
    send_instr(OP_SET, 0, 64'h8000_0000_0000_0000, 0);
    send_instr(OP_SET, 1, -64'sd1, 0);
    send_instr(OP_SET, 2, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    send_instr(OP_SET, 1023, 5, 0);
    send_instr(OP_SET, 3, 1023, 0);
    send_instr(OP_LOAD, 4, 3, 0);
    send_instr(OP_STORE, 3, 2, 0);
    send_instr(OP_DIV, 5, 0, 1);
    send_instr(OP_MOD, 6, 0, 1);
    send_instr(OP_DIV, 7, 1, 3);
    send_instr(OP_MOD, 8, 2, 4);
    send_instr(OP_ADD, 9, 2, 2);
    send_instr(OP_MUL, 10, 2, 1);
    send_instr(OP_JUMP, 2, 0, 0);
    send_instr(OP_SGZ, 2, 0, 0);
    send_instr(OP_SGZ, 1, 0, 0);
    send_instr(OP_SGZ, 11, 0, 0);
    send_instr(OP_OUT, 2, 0, 0);
    send_instr(OP_SLEEP, 0, 0, 0);
    send_instr(OP_SLEEP, 2, 0, 0);
    send_instr(OP_SLEEP, 1, 0, 0);
  endtask

  // errors each halt the block; reset is never repeated, so one halting
  // sequence ends the run: a negative jump target, then requests while halted
  task automatic test_halt();
    send_instr(OP_SET, 0, -64'sd1, 0);
    send_instr(OP_JUMP, 0, 0, 0);
    send_instr(OP_NOP, 0, 0, 0);
    send_instr(OP_SET, 0, 0, 0);
  endtask

  // random programs at the current memory size, well-formed unless allow_err is set
  task automatic test_random(int count, bit allow_err);
    logic [7:0] op;
    logic [63:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      op = rand_op(1'b0);
      a = rand_addr();
      b = (op == OP_SET) ? rand_value() : rand_addr();
      c = rand_addr();
      if (!allow_err) begin
        // keep the block running: replace anything that would halt it
        logic saved_halted;
        logic [63:0] saved_mem [MemWords];
        exec_result_t probe;
        saved_halted = model_halted;
        saved_mem = model_mem;
        probe = execute_instr(op, a, b, c);
        model_mem = saved_mem;
        model_halted = saved_halted;
        if (probe.status != ST_OK) begin
          if (op == OP_DIV || op == OP_MOD) begin
            op = OP_SET;
            c = 0;
          end else op = OP_SGZ;
          a = 64'($urandom_range(0, model_words > 0 ? 0 : 0));
          b = rand_value();
          if (model_words == 0) op = OP_NOP;
        end
      end
      send_instr(op, a, b, c, i % 64 < 48);
    end
  endtask

  // randomly stall the result side, with stretches of steady ready
  always @(negedge clk) begin
    if (!ready_random) out_ready <= 1'b1;
    else if ($urandom_range(0, 39) == 0) out_ready <= 1'b0;
    else if (!out_ready && $urandom_range(0, 3) == 0) out_ready <= 1'b1;
    else if (out_ready == 1'bx) out_ready <= 1'b1;
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("MISMATCH unexpected result %0d", result_count);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_redirect !== want.redirect)
          report_mismatch("redirect", out_redirect, want.redirect);
        if (out_jump_target !== want.jump_target)
          report_mismatch("jump_target", out_jump_target, want.jump_target);
        if (out_char_valid !== want.char_valid)
          report_mismatch("char_valid", out_char_valid, want.char_valid);
        if (out_out_char !== want.out_char)
          report_mismatch("out_char", out_out_char, want.out_char);
        if (out_sleep_seconds !== want.sleep_seconds)
          report_mismatch("sleep_seconds", out_sleep_seconds, want.sleep_seconds);
      end
    end
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("word_memory_vm_execute verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MemWords; i++) model_mem[i] = '0;
    model_halted = 1'b0;
    model_words = 11'd1024;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(300, 1'b0);
    set_ram_words(11'd2047);
    test_random(200, 1'b0);
    set_ram_words(11'd16);
    test_random(250, 1'b0);
    set_ram_words(11'd1);
    test_random(80, 1'b0);
    set_ram_words(11'd0);
    test_random(40, 1'b0);
    set_ram_words(11'd1023);
    ready_random = 1'b0;
    test_random(300, 1'b0);
    ready_random = 1'b1;
    test_halt();
    test_random(30, 1'b1);
    send_instr(8'd255, 0, 0, 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Ran %0d requests, %0d results, over memory sizes 1024, 2047, 16, 1, 0",
             request_count, result_count);
    $display("and 1023, ending with the halt path; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("word_memory_vm_execute verification clean");
    end else begin
      $display("word_memory_vm_execute verification failed");
    end
    $finish;
  end

endmodule
